// ===== rtl/gcmse_pkg.sv =====
// Shared types and constants for the graph coloring move score engine.
// No dependencies; imported by the core.
`default_nettype none
package gcmse_pkg;

  localparam int unsigned NODES  = 256;
  localparam int unsigned COLORS = 32;
  localparam int unsigned NODE_W = 8;
  localparam int unsigned COLOR_W = 5;

  localparam logic [2:0] CMD_LOAD  = 3'd0;
  localparam logic [2:0] CMD_SET   = 3'd1;
  localparam logic [2:0] CMD_BUILD = 3'd2;
  localparam logic [2:0] CMD_FLIP  = 3'd3;
  localparam logic [2:0] CMD_PICK  = 3'd4;

  localparam logic [5:0] NUM_COLORS_RST = 6'd32;

  // One row of the node memory: color, conflict count, gains and leave stamps.
  typedef struct packed {
    logic [COLORS-1:0][31:0] stamp;
    logic [COLORS-1:0][8:0]  gain;
    logic [7:0]              cnt;
    logic [COLOR_W-1:0]      color;
  } node_row_t;

endpackage
`default_nettype wire

// ===== rtl/graph_coloring_move_score_engine_core.sv =====
// Graph coloring move score engine: top level with the adjacency and node memories.
// Depends on gcmse_pkg.
//
//  channel  | signals                                            | handshake
//  ---------+----------------------------------------------------+---------------------------
//  command  | command_i node_a_i node_b_i color_i step_number_i  | start_i && !busy_o
//  result   | move_found_o move_node_o move_color_o              | result_valid_o, one cycle
//           | conflict_edges_o node_conflicts_o                  |
//  config   | cfg_wdata_i (num_colors)                           | cfg_we_i
//
// Every item ends with its result strobe; the block passes through idle before the next item
// is taken. The node memory has one read port and one write port: every neighbor of a flip
// costs one read and one write of its node row, and build reads the color of every node once
// per scored node. After reset a clearing pass zeroes one row of each memory per cycle with
// busy_o high. The receiver cannot stall: each result shows for exactly one cycle and
// the block returns to idle right after it.
`default_nettype none
module graph_coloring_move_score_engine_core
  import gcmse_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  output logic                   busy_o,
  input  wire logic [2:0]        command_i,
  input  wire logic [7:0]        node_a_i,
  input  wire logic [7:0]        node_b_i,
  input  wire logic [4:0]        color_i,
  input  wire logic [31:0]       step_number_i,
  input  wire logic              cfg_we_i,
  input  wire logic [5:0]        cfg_wdata_i,
  output logic                   result_valid_o,
  output logic                   move_found_o,
  output logic [7:0]             move_node_o,
  output logic [4:0]             move_color_o,
  output logic [14:0]            conflict_edges_o,
  output logic [7:0]             node_conflicts_o
);

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_L_RDA  = 5'd1;
  localparam logic [4:0] ST_L_WRA  = 5'd2;
  localparam logic [4:0] ST_L_RDB  = 5'd3;
  localparam logic [4:0] ST_L_WRB  = 5'd4;
  localparam logic [4:0] ST_S_RD   = 5'd5;
  localparam logic [4:0] ST_S_WR   = 5'd6;
  localparam logic [4:0] ST_B_RD   = 5'd7;
  localparam logic [4:0] ST_B_SCAN = 5'd8;
  localparam logic [4:0] ST_B_WR   = 5'd9;
  localparam logic [4:0] ST_F_RD   = 5'd10;
  localparam logic [4:0] ST_F_MOD  = 5'd11;
  localparam logic [4:0] ST_F_NRD  = 5'd12;
  localparam logic [4:0] ST_F_NWR  = 5'd13;
  localparam logic [4:0] ST_P_RD   = 5'd14;
  localparam logic [4:0] ST_P_SCAN = 5'd15;
  localparam logic [4:0] ST_R_RD   = 5'd16;
  localparam logic [4:0] ST_RESULT = 5'd17;
  localparam logic [4:0] ST_CLR    = 5'd18;

  // Memories and their registered read data
  node_row_t          node_mem [NODES];
  logic [NODES-1:0]   adj_mem  [NODES];
  node_row_t          node_rd_q;
  logic [NODES-1:0]   adj_rd_q;

  logic               node_re, node_we, adj_re, adj_we;
  logic [7:0]         node_raddr, node_waddr, adj_raddr, adj_waddr;
  node_row_t          node_wdata;
  logic [NODES-1:0]   adj_wdata;

  node_row_t          nrow;
  logic [NODES-1:0]   arow;

  // Control and work registers
  logic [4:0]         state_q, state_d;
  logic [2:0]         cmd_q;
  logic [7:0]         a_q, b_q;
  logic [4:0]         col_q;
  logic [31:0]        step_q;
  logic [5:0]         ncfg_q;
  logic [7:0]         n_q, n_d;
  logic [8:0]         idx_q, idx_d;
  logic [4:0]         cidx_q, cidx_d;
  logic [COLORS-1:0][7:0] cnt_q, cnt_d;
  logic [15:0]        sum_q, sum_d;
  logic [14:0]        total_q, total_d;
  logic [4:0]         oc_q, oc_d;
  logic [4:0]         ncol_q, ncol_d;
  logic [NODES-1:0]   adj_q, adj_d;
  logic               found_q, found_d;
  logic [7:0]         mnode_q, mnode_d;
  logic [4:0]         mcolor_q, mcolor_d;
  logic [31:0]        best_q, best_d;

  assign nrow = node_rd_q;
  assign arow = adj_rd_q;

  // Hold the memory arrays; read data registered
  always_ff @(posedge clk_i) begin
    if (node_we) begin
      node_mem[node_waddr] <= node_wdata;
    end
    if (node_re) begin
      node_rd_q <= node_mem[node_raddr];
    end
    if (adj_we) begin
      adj_mem[adj_waddr] <= adj_wdata;
    end
    if (adj_re) begin
      adj_rd_q <= adj_mem[adj_raddr];
    end
  end

  // Sequencer
  always_comb begin
    node_row_t   w;
    logic [8:0]  ng;
    logic [8:0]  d;
    logic [4:0]  cm;
    logic [7:0]  own;
    logic [8:0]  g;
    logic [31:0] st;

    state_d  = state_q;
    n_d      = n_q;
    idx_d    = idx_q;
    cidx_d   = cidx_q;
    cnt_d    = cnt_q;
    sum_d    = sum_q;
    total_d  = total_q;
    oc_d     = oc_q;
    ncol_d   = ncol_q;
    adj_d    = adj_q;
    found_d  = found_q;
    mnode_d  = mnode_q;
    mcolor_d = mcolor_q;
    best_d   = best_q;

    node_re    = 1'b0;
    node_we    = 1'b0;
    adj_re     = 1'b0;
    adj_we     = 1'b0;
    node_raddr = a_q;
    node_waddr = a_q;
    adj_raddr  = a_q;
    adj_waddr  = a_q;
    node_wdata = nrow;
    adj_wdata  = arow;

    w   = nrow;
    ng  = '0;
    d   = '0;
    cm  = nrow.color;
    own = cnt_q[ncol_q];
    g   = nrow.gain[cidx_q];
    st  = nrow.stamp[cidx_q];

    case (state_q)
      // Zero one row of each memory per cycle after reset
      ST_CLR: begin
        node_we    = 1'b1;
        node_waddr = n_q;
        node_wdata = '0;
        adj_we     = 1'b1;
        adj_waddr  = n_q;
        adj_wdata  = '0;
        n_d        = n_q + 8'd1;
        if (n_q == 8'(NODES - 1)) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (start_i) begin
          found_d  = 1'b0;
          mnode_d  = '0;
          mcolor_d = '0;
          n_d      = '0;
          sum_d    = '0;
          case (command_i)
            CMD_LOAD:  state_d = ST_L_RDA;
            CMD_SET:   state_d = ST_S_RD;
            CMD_BUILD: state_d = ST_B_RD;
            CMD_FLIP:  state_d = ST_F_RD;
            CMD_PICK:  state_d = ST_P_RD;
            default:   state_d = ST_R_RD;
          endcase
        end
      end

      // Load edge: set the bit in both rows; a self-loop is skipped
      ST_L_RDA: begin
        if (a_q == b_q) begin
          state_d = ST_R_RD;
        end else begin
          adj_re    = 1'b1;
          adj_raddr = a_q;
          state_d   = ST_L_WRA;
        end
      end
      ST_L_WRA: begin
        adj_we          = 1'b1;
        adj_waddr       = a_q;
        adj_wdata       = arow;
        adj_wdata[b_q]  = 1'b1;
        state_d         = ST_L_RDB;
      end
      ST_L_RDB: begin
        adj_re    = 1'b1;
        adj_raddr = b_q;
        state_d   = ST_L_WRB;
      end
      ST_L_WRB: begin
        adj_we         = 1'b1;
        adj_waddr      = b_q;
        adj_wdata      = arow;
        adj_wdata[a_q] = 1'b1;
        state_d        = ST_R_RD;
      end

      // Set color
      ST_S_RD: begin
        node_re    = 1'b1;
        node_raddr = a_q;
        state_d    = ST_S_WR;
      end
      ST_S_WR: begin
        w.color    = col_q;
        node_we    = 1'b1;
        node_waddr = a_q;
        node_wdata = w;
        state_d    = ST_R_RD;
      end

      // Build: per node, count neighbor colors, then write the whole row
      ST_B_RD: begin
        node_re    = 1'b1;
        node_raddr = n_q;
        adj_re     = 1'b1;
        adj_raddr  = n_q;
        idx_d      = '0;
        state_d    = ST_B_SCAN;
      end
      ST_B_SCAN: begin
        if (idx_q == 9'd0) begin
          ncol_d = nrow.color;
          adj_d  = arow;
          cnt_d  = '0;
        end else if (adj_q[idx_q[7:0] - 8'd1]) begin
          cnt_d[cm] = cnt_q[cm] + 8'd1;
        end
        if (idx_q[8]) begin
          state_d = ST_B_WR;
        end else begin
          node_re    = 1'b1;
          node_raddr = idx_q[7:0];
          idx_d      = idx_q + 9'd1;
        end
      end
      ST_B_WR: begin
        w.color = ncol_q;
        w.cnt   = own;
        for (int c = 0; c < COLORS; c++) begin
          w.gain[c]  = {1'b0, own} - {1'b0, cnt_q[c]};
          w.stamp[c] = '0;
        end
        node_we    = 1'b1;
        node_waddr = n_q;
        node_wdata = w;
        sum_d      = sum_q + {8'd0, own};
        if (n_q == 8'(NODES - 1)) begin
          total_d = sum_d[15:1];
          state_d = ST_R_RD;
        end else begin
          n_d     = n_q + 8'd1;
          state_d = ST_B_RD;
        end
      end

      // Flip: update the node, then walk its neighbors unless the color is unchanged
      ST_F_RD: begin
        node_re    = 1'b1;
        node_raddr = a_q;
        adj_re     = 1'b1;
        adj_raddr  = a_q;
        state_d    = ST_F_MOD;
      end
      ST_F_MOD: begin
        w.stamp[nrow.color] = step_q;
        if (col_q != nrow.color) begin
          ng = nrow.gain[col_q];
          for (int c = 0; c < COLORS; c++) begin
            w.gain[c] = nrow.gain[c] - ng;
          end
          w.cnt   = nrow.cnt - ng[7:0];
          w.color = col_q;
          state_d = ST_F_NRD;
        end else begin
          state_d = ST_R_RD;
        end
        node_we    = 1'b1;
        node_waddr = a_q;
        node_wdata = w;
        oc_d       = nrow.color;
        adj_d      = arow;
        idx_d      = '0;
      end
      ST_F_NRD: begin
        if (idx_q[8]) begin
          state_d = ST_R_RD;
        end else if (adj_q[idx_q[7:0]] && (idx_q[7:0] != a_q)) begin
          node_re    = 1'b1;
          node_raddr = idx_q[7:0];
          state_d    = ST_F_NWR;
        end else begin
          idx_d = idx_q + 9'd1;
        end
      end
      ST_F_NWR: begin
        for (int c = 0; c < COLORS; c++) begin
          if (cm == oc_q) begin
            d = ((5'(c) != oc_q) ? 9'h1FF : 9'h000) + ((5'(c) == col_q) ? 9'h1FF : 9'h000);
          end else if (cm == col_q) begin
            d = ((5'(c) != col_q) ? 9'h001 : 9'h000) + ((5'(c) == oc_q) ? 9'h001 : 9'h000);
          end else begin
            d = ((5'(c) == oc_q) ? 9'h001 : 9'h000) + ((5'(c) == col_q) ? 9'h1FF : 9'h000);
          end
          w.gain[c] = nrow.gain[c] + d;
        end
        if (cm == oc_q) begin
          w.cnt   = nrow.cnt - 8'd1;
          total_d = total_q - 15'd1;
        end else if (cm == col_q) begin
          w.cnt   = nrow.cnt + 8'd1;
          total_d = total_q + 15'd1;
        end
        node_we    = 1'b1;
        node_waddr = idx_q[7:0];
        node_wdata = w;
        idx_d      = idx_q + 9'd1;
        state_d    = ST_F_NRD;
      end

      // Pick: one row read per node, one color examined per cycle
      ST_P_RD: begin
        node_re    = 1'b1;
        node_raddr = n_q;
        cidx_d     = '0;
        state_d    = ST_P_SCAN;
      end
      ST_P_SCAN: begin
        if (({1'b0, cidx_q} < ncfg_q) && (g != 9'd0) && !g[8] &&
            (!found_q || (st < best_q))) begin
          found_d  = 1'b1;
          best_d   = st;
          mnode_d  = n_q;
          mcolor_d = cidx_q;
        end
        cidx_d = cidx_q + 5'd1;
        if (cidx_q == 5'(COLORS - 1)) begin
          if (n_q == 8'(NODES - 1)) begin
            state_d = ST_R_RD;
          end else begin
            n_d     = n_q + 8'd1;
            state_d = ST_P_RD;
          end
        end
      end

      // Fetch node_a's count for the result
      ST_R_RD: begin
        node_re    = 1'b1;
        node_raddr = a_q;
        state_d    = ST_RESULT;
      end
      ST_RESULT: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
      n_q     <= '0;
      total_q <= '0;
      ncfg_q  <= NUM_COLORS_RST;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
      total_q <= total_d;
      found_q <= found_d;
      if (cfg_we_i) begin
        ncfg_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start_i) begin
      cmd_q  <= command_i;
      a_q    <= node_a_i;
      b_q    <= node_b_i;
      col_q  <= color_i;
      step_q <= step_number_i;
    end
    idx_q    <= idx_d;
    cidx_q   <= cidx_d;
    cnt_q    <= cnt_d;
    sum_q    <= sum_d;
    oc_q     <= oc_d;
    ncol_q   <= ncol_d;
    adj_q    <= adj_d;
    mnode_q  <= mnode_d;
    mcolor_q <= mcolor_d;
    best_q   <= best_d;
  end

  assign busy_o           = (state_q != ST_IDLE);
  assign result_valid_o   = (state_q == ST_RESULT);
  assign move_found_o     = found_q && (cmd_q == CMD_PICK);
  assign move_node_o      = mnode_q;
  assign move_color_o     = mcolor_q;
  assign conflict_edges_o = total_q;
  assign node_conflicts_o = nrow.cnt;

endmodule
`default_nettype wire

// ===== rtl/gcmse_checker.sv =====
// Port-level checks for the move score engine core, bound to the top level.
// Depends on graph_coloring_move_score_engine_core ports only.
`default_nettype none
module gcmse_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start_i,
  input wire logic        busy_o,
  input wire logic        result_valid_o,
  input wire logic        move_found_o,
  input wire logic [7:0]  move_node_o,
  input wire logic [4:0]  move_color_o
);

  // Strobe only while an item is in work
  a_strobe_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy_o) else $error("result strobe while idle");

  // Strobe lasts one cycle and ends the item
  a_strobe_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> (!result_valid_o && !busy_o)) else $error("strobe did not end item");

  // An accepted item makes the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("accepted item not taken");

  // No move reports a zero move
  a_no_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !move_found_o) |-> ((move_node_o == 8'd0) && (move_color_o == 5'd0)))
    else $error("move fields set without a move");

endmodule

bind graph_coloring_move_score_engine_core gcmse_checker u_gcmse_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .result_valid_o (result_valid_o),
  .move_found_o   (move_found_o),
  .move_node_o    (move_node_o),
  .move_color_o   (move_color_o)
);
`default_nettype wire
